>>> src/svic_pkg.sv
package svic_pkg;

  localparam logic [2:0] FN_INT32   = 3'd0;
  localparam logic [2:0] FN_UINT32  = 3'd1;
  localparam logic [2:0] FN_INTEGER = 3'd2;
  localparam logic [2:0] FN_BOOLEAN = 3'd3;
  localparam logic [2:0] FN_NUMBER  = 3'd4;

  localparam logic [2:0] VT_UNDEF  = 3'd0;
  localparam logic [2:0] VT_NULL   = 3'd1;
  localparam logic [2:0] VT_BOOL   = 3'd2;
  localparam logic [2:0] VT_NUMBER = 3'd3;
  localparam logic [2:0] VT_STRING = 3'd4;
  localparam logic [2:0] VT_SYMBOL = 3'd5;
  localparam logic [2:0] VT_BIGINT = 3'd6;
  localparam logic [2:0] VT_OBJECT = 3'd7;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] SAT_HIGH  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_LOW   = 64'h8000_0000_0000_0000;
  localparam logic [10:0] EXP_BIAS  = 11'd1023;
  localparam logic [10:0] EXP_ALL   = 11'h7FF;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  value_type;
    logic [63:0] value_bits;
  } svic_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        deferred;
  } svic_out_t;

endpackage

>>> src/script_value_to_integer_convert.sv
// Stateless script value conversion pipeline: one request per cycle while the output is not
// stalled; each result passes through the registered stages (type decode, exponent classify,
// barrel shift, negate and select); stall from the output backs up through all stages with no loss.
module script_value_to_integer_convert
  import svic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  svic_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output svic_out_t out_data
);

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: type decode
  logic        v1;
  logic [2:0]  fn1;
  logic [63:0] d1;
  logic        def1, bool1;
  logic [63:0] d1_next;
  logic        bool1_next;

  always_comb begin
    unique case (in_data.value_type)
      VT_NULL:   d1_next = '0;
      VT_BOOL:   d1_next = in_data.value_bits[0] ? ONE_BITS : '0;
      VT_NUMBER: d1_next = in_data.value_bits;
      default:   d1_next = QNAN_BITS;
    endcase
    case (in_data.value_type)
      VT_BOOL:   bool1_next = in_data.value_bits[0];
      VT_NUMBER: bool1_next = (in_data.value_bits[62:0] != '0) &&
                              !((in_data.value_bits[62:52] == EXP_ALL) &&
                                (in_data.value_bits[51:0] != '0));
      VT_SYMBOL: bool1_next = 1'b1;
      default:   bool1_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      fn1   <= in_data.func;
      d1    <= d1_next;
      bool1 <= bool1_next;
      def1  <= (in_data.value_type == VT_STRING) || (in_data.value_type == VT_OBJECT);
    end
  end

  // stage 2: exponent classify
  logic        v2, def2, bool2, neg2, nan2, inf2, big2, small2, left2;
  logic [2:0]  fn2;
  logic [63:0] d2;
  logic [52:0] m2;
  logic [5:0]  sh2;
  logic [10:0] e1;
  logic [10:0] k1;
  assign e1 = d1[62:52];
  assign k1 = e1 - EXP_BIAS;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      fn2    <= fn1;
      d2     <= d1;
      def2   <= def1;
      bool2  <= bool1;
      neg2   <= d1[63];
      nan2   <= (e1 == EXP_ALL) && (d1[51:0] != '0);
      inf2   <= (e1 == EXP_ALL) && (d1[51:0] == '0);
      big2   <= (e1 != EXP_ALL) && (e1 >= EXP_BIAS) && (k1 >= 11'd63);
      small2 <= (e1 < EXP_BIAS) || (e1 == EXP_ALL) ||
                ((e1 != EXP_ALL) && (k1 >= 11'd116));
      m2     <= {1'b1, d1[51:0]};
      left2  <= (e1 >= EXP_BIAS) && (k1 > 11'd52);
      sh2    <= (k1 > 11'd52) ? 6'((k1 - 11'd52)) : 6'((11'd52 - k1));
    end
  end

  // stage 3: barrel shift
  logic        v3, def3, bool3, neg3, nan3, inf3, big3;
  logic [2:0]  fn3;
  logic [63:0] d3, mag3;
  logic [63:0] mag3_next;

  always_comb begin
    if (small2) mag3_next = '0;
    else if (left2) mag3_next = {11'd0, m2} << sh2;
    else mag3_next = {11'd0, m2} >> sh2;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      fn3 <= fn2; d3 <= d2; def3 <= def2; bool3 <= bool2;
      neg3 <= neg2; nan3 <= nan2; inf3 <= inf2; big3 <= big2;
      mag3 <= mag3_next;
    end
  end

  // stage 4: negate and select
  logic [63:0] sgn3, res_next;
  assign sgn3 = neg3 ? (64'd0 - mag3) : mag3;

  always_comb begin
    res_next = '0;
    if (!def3) begin
      unique case (fn3)
        FN_INT32, FN_UINT32: res_next = (nan3 || inf3) ? '0 : {32'd0, sgn3[31:0]};
        FN_INTEGER: begin
          if (nan3) res_next = '0;
          else if (inf3 || big3) res_next = neg3 ? SAT_LOW : SAT_HIGH;
          else res_next = sgn3;
        end
        FN_BOOLEAN: res_next = {63'd0, bool3};
        FN_NUMBER:  res_next = d3;
        default:    res_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v3;
    if (adv) begin
      out_data.result_bits <= res_next;
      out_data.deferred    <= def3;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_def_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.deferred |-> out_data.result_bits == '0)
    else $error("deferred request with nonzero result");
  a_bool_range: assert property (@(posedge clk) disable iff (rst)
    v3 && adv && fn3 == FN_BOOLEAN |=> out_data.result_bits[63:1] == '0)
    else $error("boolean result out of range");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

>>> tb/tb_top.sv
module tb_top;
  import svic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class conv_scoreboard;
    svic_out_t pending[$];
    bit failed;

    function logic [63:0] number_of(logic [2:0] vt, logic [63:0] b);
      case (vt)
        VT_NULL:   return 64'd0;
        VT_BOOL:   return b[0] ? ONE_BITS : 64'd0;
        VT_NUMBER: return b;
        default:   return QNAN_BITS;
      endcase
    endfunction

    // truncated magnitude, big when >= 2^63 or infinite
    function logic [63:0] trunc_mag(logic [63:0] d, output bit big, output bit nan);
      logic [10:0] e;
      logic [63:0] m;
      int k;
      e = d[62:52];
      m = {11'd0, 1'b1, d[51:0]};
      big = 0;
      nan = 0;
      if (e == EXP_ALL) begin
        if (d[51:0] != 0) nan = 1;
        else big = 1;
        return 64'd0;
      end
      if (e < EXP_BIAS) return 64'd0;
      k = e - EXP_BIAS;
      if (k >= 63) big = 1;
      if (k <= 52) return m >> (52 - k);
      if (k - 52 >= 64) return 64'd0;
      return m << (k - 52);
    endfunction

    function svic_out_t convert(svic_in_t r);
      svic_out_t o;
      logic [63:0] d, mag, sgn;
      bit big, nan;
      o.deferred = 0;
      o.result_bits = 0;
      if (r.value_type == VT_STRING || r.value_type == VT_OBJECT) begin
        o.deferred = 1;
        return o;
      end
      d = number_of(r.value_type, r.value_bits);
      mag = trunc_mag(d, big, nan);
      sgn = d[63] ? (64'd0 - mag) : mag;
      case (r.func)
        FN_INT32, FN_UINT32: begin
          if (!nan && d[62:52] != EXP_ALL)
            o.result_bits = {32'd0, sgn[31:0]};
        end
        FN_INTEGER: begin
          if (nan) o.result_bits = 0;
          else if (big) o.result_bits = d[63] ? SAT_LOW : SAT_HIGH;
          else o.result_bits = sgn;
        end
        FN_BOOLEAN: begin
          case (r.value_type)
            VT_BOOL: o.result_bits = {63'd0, r.value_bits[0]};
            VT_NUMBER: o.result_bits = {63'd0, (r.value_bits[62:0] != 0) &&
                !(r.value_bits[62:52] == EXP_ALL && r.value_bits[51:0] != 0)};
            VT_SYMBOL: o.result_bits = 1;
            default: o.result_bits = 0;
          endcase
        end
        FN_NUMBER: o.result_bits = d;
        default: o.result_bits = 0;
      endcase
      return o;
    endfunction

    function void note_request(svic_in_t r);
      pending.push_back(convert(r));
    endfunction

    function void check_result(svic_out_t got);
      svic_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1;
        return;
      end
      want = pending.pop_front();
      if (got.result_bits !== want.result_bits) begin
        $display("%0t: result_bits expected %h actual %h", $time, want.result_bits,
                 got.result_bits);
        failed = 1;
      end
      if (got.deferred !== want.deferred) begin
        $display("%0t: deferred expected %b actual %b", $time, want.deferred, got.deferred);
        failed = 1;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  svic_in_t in_data = '0;
  svic_out_t out_data;
  conv_scoreboard sb = new();
  svic_in_t reqs[$];
  int idle_cycles = 0;
  bit sending_done = 0;

  script_value_to_integer_convert uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver raises out_stall at random before each result
  initial begin
    int w;
    @(posedge clk);
    forever begin
      w = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) w = 0;
      if (w != 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [63:0] rand_double();
    logic [63:0] b;
    logic [10:0] e;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: e = 11'(11'd1023 + $urandom_range(0, 31));
      1: e = 11'(11'd1023 + $urandom_range(0, 70));
      2: e = 11'(11'd1000 + $urandom_range(0, 30));
      3: e = $urandom_range(0, 1) ? EXP_ALL : 11'd0;
      default: e = b[62:52];
    endcase
    if ($urandom_range(0, 7) == 0) b[51:0] = 0;
    b[62:52] = e;
    return b;
  endfunction

  task automatic add_req(logic [2:0] f, logic [2:0] vt, logic [63:0] b);
    svic_in_t r;
    r.func = f;
    r.value_type = vt;
    r.value_bits = b;
    reqs.push_back(r);
  endtask

  task automatic send_all();
    svic_in_t r;
    int w;
    while (reqs.size() > 0) begin
      r = reqs.pop_front();
      w = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) w = 0;
      if (w != 0) begin
        in_valid <= 0;
        repeat (w) @(posedge clk);
      end
      in_valid <= 1;
      in_data <= r;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_request(r);
    end
    in_valid <= 0;
  endtask

  initial begin
    logic [63:0] dirs[$];
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    dirs = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
             64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
             64'h41DF_FFFF_FFC0_0000, 64'hC1E0_0000_0000_0000, 64'h43E0_0000_0000_0000,
             64'hC3E0_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
             64'h41F0_0000_0000_0000, 64'hBFF8_0000_0000_0000};
    foreach (dirs[i]) add_req(3'(i % 5), VT_NUMBER, dirs[i]);
    for (int f = 0; f < 8; f++) add_req(3'(f), 3'(f), 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FN_NUMBER, VT_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
    add_req(FN_BOOLEAN, VT_NUMBER, 64'h8000_0000_0000_0000);
    add_req(FN_INTEGER, VT_NUMBER, 64'h7FEF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 650; i++) begin
      logic [2:0] f, vt;
      f = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      vt = ($urandom_range(0, 1) == 0) ? VT_NUMBER : 3'($urandom_range(0, 7));
      add_req(f, vt, (vt == VT_NUMBER) ? rand_double() : {$urandom, $urandom});
    end
    send_all();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!sb.failed) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> script_value_to_integer_convert.f
src/svic_pkg.sv
src/script_value_to_integer_convert.sv
tb/tb_top.sv
